FILE: src/mewd_pkg.sv
// shared types and constants for the encoded word decoder
// no dependencies; imported by the front, queue, back, top level and checker
`default_nettype none

package mewd_pkg;

    // width of the space counter; low bits of space_limit that are used
    localparam int LIMIT_WIDTH = 16;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // most results one item can cause
    localparam int MAX_RESULTS = 3;

    // end marker status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ENC = 2'd1,
        ST_TRUNC   = 2'd2
    } status_t;

    // work handed from front to back: one to three results
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [1:0]                  count;
        logic                        marker;
        status_t                     status;
    } job_t;

    // queue fill state seen by the top level and the back part
    typedef struct packed {
        logic empty;
        logic full;
    } q_flags_t;

endpackage

`default_nettype wire

FILE: src/mewd_front.sv
// front part: accepts bytes, tracks word state and turns each byte that gives results or a marker into a job
// depends on mewd_pkg
`default_nettype none

module mewd_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       in_byte,
    input  wire logic             word_start,
    input  wire logic [15:0]      space_limit,
    output mewd_pkg::job_t        job,
    output logic                  push
);
    import mewd_pkg::*;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_Q    = 2'd1,
        MODE_B    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_t;

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // {invalid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
        if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
        return r;
    endfunction

    // {skip, pad, value}
    function automatic logic [7:0] b64_decode(input logic [7:0] c);
        logic [7:0] r;
        r = 8'h80;
        if (c >= 8'h41 && c <= 8'h5A) r = {2'b00, 6'(c - 8'h41)};
        if (c >= 8'h61 && c <= 8'h7A) r = {2'b00, 6'(c - 8'h47)};
        if (c >= 8'h30 && c <= 8'h39) r = {2'b00, 6'(c + 8'h04)};
        if (c == CH_PLUS)  r = 8'd62;
        if (c == CH_SLASH) r = 8'd63;
        if (c == CH_EQ)    r = 8'h40;
        return r;
    endfunction

    logic [2:0]             qmark_reg,   qmark_next;
    mode_t                  mode_reg,    mode_next;
    logic                   bad_reg,     bad_next;
    esc_t                   esc_reg,     esc_next;
    logic [3:0]             nib_reg,     nib_next;
    logic [1:0]             qc_reg,      qc_next;
    logic [2:0][6:0]        sx_reg,      sx_next;
    logic                   stop_reg,    stop_next;
    logic [LIMIT_WIDTH-1:0] space_reg,   space_next;
    logic                   trunc_reg,   trunc_next;

    logic [MAX_RESULTS-1:0][7:0] cand;
    logic [1:0]                  ncand;
    logic [1:0]                  nout;
    logic                        mark;
    status_t                     mark_st;
    logic [4:0]                  hx;
    logic [7:0]                  bv;

    always_comb
    begin
        qmark_next = qmark_reg;
        mode_next  = mode_reg;
        bad_next   = bad_reg;
        esc_next   = esc_reg;
        nib_next   = nib_reg;
        qc_next    = qc_reg;
        sx_next    = sx_reg;
        stop_next  = stop_reg;
        space_next = space_reg;
        trunc_next = trunc_reg;
        cand       = '0;
        ncand      = 2'd0;
        nout       = 2'd0;
        mark       = 1'b0;
        mark_st    = ST_OK;
        hx         = hex_decode(in_byte);
        bv         = b64_decode(in_byte);

        // new word clears everything and loads the space
        if (word_start)
        begin
            qmark_next = '0;
            mode_next  = MODE_NONE;
            bad_next   = 1'b0;
            esc_next   = ESC_IDLE;
            nib_next   = '0;
            qc_next    = '0;
            sx_next    = '0;
            stop_next  = 1'b0;
            trunc_next = 1'b0;
            space_next = space_limit[LIMIT_WIDTH-1:0];
        end

        if (in_byte == CH_QMARK)
        begin
            if (qmark_next < 3'd4)
            begin
                qmark_next = qmark_next + 3'd1;
                if (qmark_next == 3'd3 && mode_next == MODE_NONE)
                    bad_next = 1'b1;
                if (qmark_next == 3'd4)
                begin
                    mark    = 1'b1;
                    mark_st = bad_next ? ST_BAD_ENC : (trunc_next ? ST_TRUNC : ST_OK);
                end
            end
        end
        else if (qmark_next == 3'd2)
        begin
            // letter field: only the first byte counts
            if (mode_next == MODE_NONE && !bad_next)
            begin
                if (in_byte == 8'h51 || in_byte == 8'h71)
                    mode_next = MODE_Q;
                else if (in_byte == 8'h42 || in_byte == 8'h62)
                    mode_next = MODE_B;
                else
                    bad_next = 1'b1;
            end
        end
        else if (qmark_next == 3'd3 && !bad_next)
        begin
            if (mode_next == MODE_Q)
            begin
                case (esc_next)
                    ESC_HIGH:
                    begin
                        nib_next = hx[4] ? 4'hF : hx[3:0];
                        esc_next = ESC_LOW;
                    end
                    ESC_LOW:
                    begin
                        esc_next = ESC_IDLE;
                        cand[0]  = hx[4] ? 8'hFF : {nib_next, hx[3:0]};
                        ncand    = 2'd1;
                    end
                    default:
                    begin
                        if (in_byte == CH_EQ)
                            esc_next = ESC_HIGH;
                        else
                        begin
                            cand[0] = (in_byte == CH_UNDER) ? CH_SPACE : in_byte;
                            ncand   = 2'd1;
                        end
                    end
                endcase
            end
            else if (mode_next == MODE_B)
            begin
                if (!stop_next && !bv[7])
                begin
                    case (qc_next)
                        2'd0:    begin sx_next[0] = bv[6:0]; qc_next = 2'd1; end
                        2'd1:    begin sx_next[1] = bv[6:0]; qc_next = 2'd2; end
                        2'd2:    begin sx_next[2] = bv[6:0]; qc_next = 2'd3; end
                        default:
                        begin
                            // quartet complete; padding stops decoding
                            qc_next = 2'd0;
                            cand[0] = {sx_next[0][5:0], sx_next[1][5:4]};
                            cand[1] = {sx_next[1][3:0], sx_next[2][5:2]};
                            cand[2] = {sx_next[2][1:0], bv[5:0]};
                            if (sx_next[0][6] || sx_next[1][6])
                                stop_next = 1'b1;
                            else if (sx_next[2][6])
                            begin
                                stop_next = 1'b1;
                                ncand     = 2'd1;
                            end
                            else if (bv[6])
                            begin
                                stop_next = 1'b1;
                                ncand     = 2'd2;
                            end
                            else
                                ncand = 2'd3;
                        end
                    endcase
                end
            end
        end

        // bytes beyond the space are dropped and flagged
        if (LIMIT_WIDTH'(ncand) > space_next)
        begin
            nout       = space_next[1:0];
            trunc_next = 1'b1;
        end
        else
            nout = ncand;
        space_next = space_next - LIMIT_WIDTH'(nout);
    end

    always_comb
    begin
        job.data   = cand;
        job.count  = mark ? 2'd1 : nout;
        job.marker = mark;
        job.status = mark_st;
        push       = accept && (mark || nout != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qmark_reg <= '0;
            mode_reg  <= MODE_NONE;
            bad_reg   <= 1'b0;
            esc_reg   <= ESC_IDLE;
            nib_reg   <= '0;
            qc_reg    <= '0;
            sx_reg    <= '0;
            stop_reg  <= 1'b0;
            space_reg <= '0;
            trunc_reg <= 1'b0;
        end
        else if (accept)
        begin
            qmark_reg <= qmark_next;
            mode_reg  <= mode_next;
            bad_reg   <= bad_next;
            esc_reg   <= esc_next;
            nib_reg   <= nib_next;
            qc_reg    <= qc_next;
            sx_reg    <= sx_next;
            stop_reg  <= stop_next;
            space_reg <= space_next;
            trunc_reg <= trunc_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/mewd_queue.sv
// short job queue between front and back
// depends on mewd_pkg
`default_nettype none

module mewd_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mewd_pkg::job_t   push_job,
    input  wire logic             pop,
    output mewd_pkg::job_t        head,
    output mewd_pkg::q_flags_t    flags
);
    import mewd_pkg::*;

    job_t                mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg;
    logic [QPTR_W-1:0]   rd_reg;
    logic [QPTR_W:0]     cnt_reg;
    logic [QPTR_W:0]     cnt_next;

    assign head        = mem[rd_reg];
    assign flags.empty = (cnt_reg == '0);
    assign flags.full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        flags.full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        flags.empty |-> !pop)
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH)) |->
            (wr_reg != rd_reg))
        else $error("pointers disagree with fill count");

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_job.count != 2'd0))
        else $error("job with no results queued");

endmodule

`default_nettype wire

FILE: src/mewd_back.sv
// back part: takes jobs from the queue and sends their results one by one
// depends on mewd_pkg
`default_nettype none

module mewd_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mewd_pkg::job_t     head,
    input  wire mewd_pkg::q_flags_t flags,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_byte,
    output logic                    is_marker,
    output logic [1:0]              status,
    output logic                    last_of_run
);
    import mewd_pkg::*;

    job_t        cur_reg;
    logic        cur_valid_reg;
    logic [1:0]  idx_reg;
    logic        ov_reg;
    logic [7:0]  byte_reg;
    logic        mark_reg;
    status_t     st_reg;
    logic        last_reg;

    logic        load;
    logic        is_last;
    logic        done;
    logic [7:0]  sel_byte;

    always_comb
    begin
        load    = cur_valid_reg && (!ov_reg || !out_stall);
        is_last = (idx_reg == cur_reg.count - 2'd1);
        done    = load && is_last;
        pop     = !flags.empty && (!cur_valid_reg || done);
        case (idx_reg)
            2'd0:    sel_byte = cur_reg.data[0];
            2'd1:    sel_byte = cur_reg.data[1];
            2'd2:    sel_byte = cur_reg.data[2];
            default: sel_byte = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (load)
        begin
            byte_reg <= cur_reg.marker ? 8'h00 : sel_byte;
            mark_reg <= cur_reg.marker;
            st_reg   <= cur_reg.marker ? cur_reg.status : ST_OK;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (done)
                cur_valid_reg <= 1'b0;
            else if (load)
                idx_reg <= idx_reg + 2'd1;

            if (load)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid   = ov_reg;
    assign out_byte    = byte_reg;
    assign is_marker   = mark_reg;
    assign status      = st_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

FILE: src/mime_encoded_word_decoder.sv
// top level of the encoded word decoder: front, job queue and back
// depends on mewd_pkg, mewd_front, mewd_queue, mewd_back
`default_nettype none

// channel  | valid     | stall     | payload
// ---------+-----------+-----------+-----------------------------------------
// input    | in_valid  | in_stall  | in_byte, word_start, space_limit
// output   | out_valid | out_stall | out_byte, is_marker, status, last_of_run
//
// one input item is taken per cycle while the queue has room; in_stall is
// the queue full flag, so the front waits on the output side only once the queue fills
// each item gives zero to three results, sent one per cycle unless the output
// stalls, so the output port sets the sustained rate; items with no result
// use no output slot; results pass the queue, job and output registers
// reset clears all word state, the queue and the output register; no word
// needs to be started for the block to run (space is then zero)
// a stall on the output holds the output register; the queue absorbs up to
// four jobs before the input is stalled

module mime_encoded_word_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        word_start,
    input  wire logic [15:0] space_limit,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             is_marker,
    output logic [1:0]       status,
    output logic             last_of_run
);
    import mewd_pkg::*;

    job_t     new_job;
    job_t     head_job;
    q_flags_t qf;
    logic     accept;
    logic     push;
    logic     pop;

    // input is held off only while the queue is full
    assign in_stall = qf.full;
    assign accept   = in_valid && !qf.full;

    // classify bytes and update word state
    mewd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .word_start  (word_start),
        .space_limit (space_limit),
        .job         (new_job),
        .push        (push)
    );

    // decouples the per-byte front from the per-result back
    mewd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (new_job),
        .pop      (pop),
        .head     (head_job),
        .flags    (qf)
    );

    // serialise each job into results behind an output register
    mewd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_job),
        .flags       (qf),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .is_marker   (is_marker),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

FILE: sim/encoded_word_checker.sv
// checker for the encoded word decoder: watches both channels, predicts every
// result of each accepted item and compares it with what comes out
// depends on mewd_pkg for the status codes and the space counter width

module encoded_word_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        word_start,
    input  logic [15:0] space_limit,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        is_marker,
    input  logic [1:0]  status,
    input  logic        last_of_run,
    input  logic        words_done,
    output int          fail_count,
    output int          results_pending
);
    import mewd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       marker;
        status_t    st;
        logic       last;
    } word_result_t;

    typedef enum logic [1:0] {ENC_NONE, ENC_Q, ENC_B} enc_mode_t;
    typedef enum logic [1:0] {ESC_IDLE, ESC_HIGH, ESC_LOW} esc_phase_t;

    localparam logic [7:0] CH_QMARK      = 8'h3F;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_Q_UPPER    = 8'h51;
    localparam logic [7:0] CH_Q_LOWER    = 8'h71;
    localparam logic [7:0] CH_B_UPPER    = 8'h42;
    localparam logic [7:0] CH_B_LOWER    = 8'h62;
    localparam int NOT_CODED = -1;
    localparam int PAD_CODE  = 'h40;

    // word state
    logic [2:0]             qmarks;
    enc_mode_t              mode;
    logic                   bad_letter;
    esc_phase_t             esc;
    logic [3:0]             high_nib;
    int                     quartet_fill;
    logic [6:0]             sextets [3];
    logic                   b64_done;
    logic [LIMIT_WIDTH-1:0] room;
    logic                   overflowed;

    word_result_t run_results[$];
    word_result_t awaited[$];
    logic         leftovers_checked;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return NOT_CODED;
    endfunction

    function automatic int b64_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c - "A");
        if (c >= "a" && c <= "z") return int'(c - "a") + 26;
        if (c >= "0" && c <= "9") return int'(c - "0") + 52;
        if (c == CH_PLUS) return 62;
        if (c == CH_SLASH) return 63;
        if (c == CH_EQUALS) return PAD_CODE;
        return NOT_CODED;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic clear_word();
        qmarks       = '0;
        mode         = ENC_NONE;
        bad_letter   = 1'b0;
        esc          = ESC_IDLE;
        high_nib     = '0;
        quartet_fill = 0;
        foreach (sextets[i]) sextets[i] = '0;
        b64_done     = 1'b0;
        room         = '0;
        overflowed   = 1'b0;
    endtask

    // a decoded byte takes one unit of space or is lost
    task automatic put_byte(input logic [7:0] b);
        word_result_t r;
        if (room == 0)
        begin
            overflowed = 1'b1;
        end
        else
        begin
            room--;
            r.data   = b;
            r.marker = 1'b0;
            r.st     = ST_OK;
            r.last   = 1'b0;
            run_results.push_back(r);
        end
    endtask

    task automatic q_char(input logic [7:0] c);
        int h;
        h = hex_digit(c);
        case (esc)
            ESC_HIGH:
            begin
                high_nib = (h < 0) ? 4'hF : 4'(h);
                esc      = ESC_LOW;
            end
            ESC_LOW:
            begin
                esc = ESC_IDLE;
                put_byte((h < 0) ? 8'hFF : {high_nib, 4'(h)});
            end
            default:
            begin
                if (c == CH_EQUALS)
                    esc = ESC_HIGH;
                else if (c == CH_UNDERSCORE)
                    put_byte(CH_SPACE);
                else
                    put_byte(c);
            end
        endcase
    endtask

    task automatic b64_char(input logic [7:0] c);
        int         v;
        logic [6:0] s1, s2, s3, s4;
        v = b64_sextet(c);
        if (b64_done || v < 0) return;
        if (quartet_fill < 3)
        begin
            sextets[quartet_fill] = 7'(v);
            quartet_fill++;
            return;
        end
        quartet_fill = 0;
        s1 = sextets[0];
        s2 = sextets[1];
        s3 = sextets[2];
        s4 = 7'(v);
        // bit 6 marks a pad character
        if (s1[6] || s2[6])
        begin
            b64_done = 1'b1;
            return;
        end
        put_byte({s1[5:0], s2[5:4]});
        if (s3[6])
        begin
            b64_done = 1'b1;
            return;
        end
        put_byte({s2[3:0], s3[5:2]});
        if (s4[6])
        begin
            b64_done = 1'b1;
            return;
        end
        put_byte({s3[1:0], s4[5:0]});
    endtask

    task automatic decode_item(input logic [7:0] c, input logic ws, input logic [15:0] lim);
        word_result_t r;
        run_results.delete();
        if (ws)
        begin
            clear_word();
            room = LIMIT_WIDTH'(lim);
        end
        if (c == CH_QMARK)
        begin
            if (qmarks < 4)
            begin
                qmarks++;
                if (qmarks == 3 && mode == ENC_NONE) bad_letter = 1'b1;
                if (qmarks == 4)
                begin
                    r.data   = '0;
                    r.marker = 1'b1;
                    r.last   = 1'b0;
                    if (bad_letter)
                        r.st = ST_BAD_ENC;
                    else if (overflowed)
                        r.st = ST_TRUNC;
                    else
                        r.st = ST_OK;
                    run_results.push_back(r);
                end
            end
        end
        else if (qmarks == 2)
        begin
            // only the first byte of the letter field counts
            if (mode == ENC_NONE && !bad_letter)
            begin
                if (c == CH_Q_UPPER || c == CH_Q_LOWER)
                    mode = ENC_Q;
                else if (c == CH_B_UPPER || c == CH_B_LOWER)
                    mode = ENC_B;
                else
                    bad_letter = 1'b1;
            end
        end
        else if (qmarks == 3 && !bad_letter)
        begin
            if (mode == ENC_Q)
                q_char(c);
            else if (mode == ENC_B)
                b64_char(c);
        end
        if (run_results.size() > 0) run_results[run_results.size()-1].last = 1'b1;
        foreach (run_results[i]) awaited.push_back(run_results[i]);
    endtask

    task automatic check_result();
        word_result_t e;
        if (awaited.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result byte %02h marker %0b status %0d",
                                      out_byte, is_marker, status));
            return;
        end
        e = awaited.pop_front();
        if (out_byte !== e.data)
            report_mismatch($sformatf("out_byte %02h, wanted %02h", out_byte, e.data));
        if (is_marker !== e.marker)
            report_mismatch($sformatf("is_marker %0b, wanted %0b", is_marker, e.marker));
        if (status !== e.st)
            report_mismatch($sformatf("status %0d, wanted %0d", status, e.st));
        if (last_of_run !== e.last)
            report_mismatch($sformatf("last_of_run %0b, wanted %0b", last_of_run, e.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_word();
            awaited.delete();
            fail_count        = 0;
            results_pending   = 0;
            leftovers_checked = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall) check_result();
            if (in_valid && !in_stall) decode_item(in_byte, word_start, space_limit);
            if (words_done && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                foreach (awaited[i])
                    report_mismatch($sformatf("result never came: byte %02h marker %0b",
                                              awaited[i].data, awaited[i].marker));
                awaited.delete();
            end
            results_pending = awaited.size();
        end
    end

endmodule

FILE: sim/tb_mime_encoded_word_decoder.sv
// testbench top for the encoded word decoder: makes the byte stream of whole
// and broken encoded words, idles both sides and gives the verdict
// depends on mewd_pkg, mime_encoded_word_decoder and encoded_word_checker

module tb_mime_encoded_word_decoder;

    // stop point of the random part, counted in items sent
    localparam int TARGET_ITEMS = 110;
    // far above the slowest correct run
    localparam int CYCLE_LIMIT  = 20000;
    // settle time after the last result: queue of four plus output register
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] CH_QMARK      = 8'h3F;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_Q_UPPER    = 8'h51;
    localparam logic [7:0] CH_Q_LOWER    = 8'h71;
    localparam logic [7:0] CH_B_UPPER    = 8'h42;
    localparam logic [7:0] CH_B_LOWER    = 8'h62;

    localparam string HEX_CHARS   = "0123456789ABCDEFabcdef";
    localparam string B64_CHARS   =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    // skipped in base64 data: neither alphabet nor pad nor question mark
    localparam string NOISE_CHARS = " -.!*_:";

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        word_start;
    logic [15:0] space_limit;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        is_marker;
    logic [1:0]  status;
    logic        last_of_run;

    logic        words_done;
    logic        gaps_on;
    int          fail_count;
    int          results_pending;
    int          item_count;
    int          cycle_count = 0;

    // bytes of the word being built
    logic [7:0]  word_bytes[$];

    mime_encoded_word_decoder uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .word_start  (word_start),
        .space_limit (space_limit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .is_marker   (is_marker),
        .status      (status),
        .last_of_run (last_of_run)
    );

    encoded_word_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .word_start      (word_start),
        .space_limit     (space_limit),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .is_marker       (is_marker),
        .status          (status),
        .last_of_run     (last_of_run),
        .words_done      (words_done),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver back-pressure: stalls at random, 8 percent of the time, while gaps are on
    always @(posedge clk)
        out_stall <= gaps_on && ($urandom_range(99) < 8);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** mime_encoded_word_decoder: FAILED **");
            $finish;
        end
    end

    function automatic logic [7:0] any_but_qmark();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CH_QMARK);
        return c;
    endfunction

    // mostly a proper hex digit, now and then anything
    function automatic logic [7:0] hex_or_junk();
        if ($urandom_range(99) < 80) return HEX_CHARS[$urandom_range(HEX_CHARS.len()-1)];
        return any_but_qmark();
    endfunction

    function automatic logic [7:0] b64_noise();
        if ($urandom_range(1) == 1) return 8'($urandom_range(128, 255));
        return NOISE_CHARS[$urandom_range(NOISE_CHARS.len()-1)];
    endfunction

    function automatic logic [7:0] b64_any();
        return B64_CHARS[$urandom_range(63)];
    endfunction

    // small limits give truncation often, the extremes and full-width values
    // keep every bit of the limit moving
    function automatic logic [15:0] pick_limit();
        int r;
        r = $urandom_range(99);
        if (r < 12) return 16'h0000;
        if (r < 24) return 16'hFFFF;
        if (r < 44) return 16'($urandom);
        return 16'($urandom_range(1, 6));
    endfunction

    task automatic add(input logic [7:0] b);
        word_bytes.push_back(b);
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) add(s[i]);
    endtask

    // one item through the handshake, with random idle cycles before it
    task automatic send_item(input logic [7:0] b, input logic ws, input logic [15:0] lim);
        while (gaps_on && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        word_start  <= ws;
        // the limit is only read with word_start, so anything goes otherwise
        space_limit <= ws ? lim : 16'($urandom);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // fresh marks the first byte with word_start
    task automatic send_word(input logic [15:0] lim, input bit fresh);
        foreach (word_bytes[i])
        begin
            send_item(word_bytes[i], fresh && i == 0, lim);
            item_count++;
        end
        word_bytes.delete();
    endtask

    // hold the sender off until every predicted result has come out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
    endtask

    task automatic build_q_data();
        int r;
        repeat ($urandom_range(8))
        begin
            r = $urandom_range(99);
            if (r < 20)
                add(CH_UNDERSCORE);
            else if (r < 45)
            begin
                add(CH_EQUALS);
                add(hex_or_junk());
                add(hex_or_junk());
            end
            else
                add(any_but_qmark());
        end
        // escape cut short by the closing question mark
        r = $urandom_range(99);
        if (r < 8)
            add(CH_EQUALS);
        else if (r < 16)
        begin
            add(CH_EQUALS);
            add(hex_or_junk());
        end
    endtask

    task automatic build_b_data();
        int quartets;
        int pad_from;
        quartets = $urandom_range(3);
        // padding from this position of the last quartet onwards, 5 = none
        pad_from = ($urandom_range(99) < 30) ? $urandom_range(1, 4) : 5;
        for (int qi = 0; qi < quartets; qi++)
        begin
            for (int ci = 1; ci <= 4; ci++)
            begin
                if ($urandom_range(99) < 10) add(b64_noise());
                if (qi == quartets - 1 && ci >= pad_from)
                    add(CH_EQUALS);
                else
                    add(b64_any());
            end
        end
        // a whole quartet after the padding, which must be ignored
        if (pad_from <= 4 && $urandom_range(1) == 1)
            repeat (4) add(b64_any());
        // partial final quartet
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) add(b64_any());
    endtask

    // mostly well-formed words with random content; some bad or empty
    // letters, trailing bytes after the close and words cut off midway
    task automatic build_random_word();
        int         kind;
        int         cut;
        bit         q_mode;
        bit         b_mode;
        logic [7:0] c;
        q_mode = 1'b0;
        b_mode = 1'b0;
        if ($urandom_range(1) == 1) add(CH_EQUALS);
        add(CH_QMARK);
        repeat ($urandom_range(3)) add(8'($urandom_range("a", "z")));
        add(CH_QMARK);
        kind = $urandom_range(99);
        if (kind < 45)
        begin
            q_mode = 1'b1;
            add(($urandom_range(1) == 1) ? CH_Q_UPPER : CH_Q_LOWER);
        end
        else if (kind < 90)
        begin
            b_mode = 1'b1;
            add(($urandom_range(1) == 1) ? CH_B_UPPER : CH_B_LOWER);
        end
        else if (kind < 95)
        begin
            do c = any_but_qmark();
            while (c == CH_Q_UPPER || c == CH_Q_LOWER || c == CH_B_UPPER || c == CH_B_LOWER);
            add(c);
        end
        // otherwise the letter field stays empty
        if ($urandom_range(99) < 15) add(any_but_qmark());
        add(CH_QMARK);
        if (q_mode)
            build_q_data();
        else if (b_mode)
            build_b_data();
        else
            repeat ($urandom_range(3)) add(any_but_qmark());
        add(CH_QMARK);
        if ($urandom_range(99) < 70) add(CH_EQUALS);
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, 3))
                add(($urandom_range(1) == 1) ? CH_QMARK : 8'($urandom));
        // broken word: the next word_start must recover
        if ($urandom_range(99) < 8)
        begin
            cut = $urandom_range(word_bytes.size() - 1);
            while (word_bytes.size() > cut + 1)
                void'(word_bytes.pop_back());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = '0;
        word_start   = 1'b0;
        space_limit  = '0;
        words_done   = 1'b0;
        gaps_on      = 1'b1;
        item_count   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no word started since reset: space is zero, so the marker says truncated
        add_text("??Q?a?");
        send_word(16'h0000, 1'b0);

        // widest limit; underscore, a good escape, both digits bad, and an
        // escape cut short by the closing question mark
        add_text("??q?_=4a=zZ=g?");
        send_word(16'hFFFF, 1'b1);

        // base64 with padding in the third place, no space at all, and a
        // question mark after the close that must not give a second marker
        add_text("??B?QQ==??");
        send_word(16'h0000, 1'b1);

        wait_for_drain();

        while (item_count < TARGET_ITEMS)
        begin
            // a stretch in the middle runs with no idling on either side
            gaps_on <= !(item_count >= 45 && item_count < 80);
            if ($urandom_range(9) == 0) wait_for_drain();
            build_random_word();
            send_word(pick_limit(), $urandom_range(19) != 0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        // let the checker sweep for missing results before the verdict
        words_done <= 1'b1;
        repeat (3) @(posedge clk);
        if (fail_count == 0)
            $display("** mime_encoded_word_decoder: PASSED **");
        else
            $display("** mime_encoded_word_decoder: FAILED **");
        $finish;
    end

endmodule
